>>> rtl/core/root_element_name_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// root name scanner assertion macros
// assertion wrappers used by the scanner front end, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ROOT_ELEMENT_NAME_SCANNER_CORE_DEFINES_SVH
`define ROOT_ELEMENT_NAME_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RENS_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rens assertion failed: same cycle implication");
`define RENS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rens assertion failed: next cycle implication");
`else
`define RENS_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define RENS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> rtl/core/rens_pkg.sv
// ----------------------------------------------------------------------------
// root name scanner package
// shared constants, scan phases and the job record passed front to back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rens_pkg;

  localparam int NAME_DEPTH_DEF = 32;
  localparam int NAME_DEPTH_MAX = 64;
  localparam int JOB_LEN_W      = $clog2(NAME_DEPTH_MAX + 1);
  localparam int CFG_DATA_W     = 6;

  // register indexes
  localparam logic CFG_FORMAT_JSON = 1'b0;
  localparam logic CFG_NAME_LIMIT  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] NAME_LIMIT_RST = 6'd32;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BLANK_MAX = 8'd32;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_LT0,
    PH_LTSP,
    PH_HDR,
    PH_MAINLEAD,
    PH_XNAME,
    PH_JQUOTE,
    PH_JNAME,
    PH_DONE
  } phase_t;

  // one result run: an error item, or a stored name plus terminator
  typedef struct packed {
    logic                 is_name;
    logic [1:0]           code;
    logic [JOB_LEN_W-1:0] len;
    logic                 bank;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/rens_front.sv
// ----------------------------------------------------------------------------
// root name scanner front end
// takes document bytes, tracks the scan phase, stores name bytes and queues
// one job per finished document
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "root_element_name_scanner_core_defines.svh"

module rens_front #(
  parameter int NAME_DEPTH = rens_pkg::NAME_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            format_json,
  input  wire logic [rens_pkg::CFG_DATA_W-1:0] name_limit,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            has_byte,
  input  wire logic                            end_of_source,
  input  wire logic                            q_full,
  output logic                                 push,
  output rens_pkg::job_t                       push_job,
  output logic                                 mem_we,
  output logic [$clog2(NAME_DEPTH):0]          mem_waddr,
  output logic [7:0]                           mem_wdata,
  input  wire logic                            release_bank
);
  import rens_pkg::*;

  localparam int IDX_W = $clog2(NAME_DEPTH);
  localparam int LEN_W = $clog2(NAME_DEPTH + 1);
  localparam int CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STORE,
    ACT_FINISH,
    ACT_INVALID,
    ACT_OVERFLOW
  } act_t;

  phase_t           phase, phase_next, ph_byte;
  logic [LEN_W-1:0] name_length, name_length_next;
  logic             wr_bank;
  logic [1:0]       in_flight, in_flight_next;

  act_t             act;
  logic             accept;
  logic             blank;
  logic             at_limit;
  logic [CMP_W-1:0] lim_ext, depth_c, eff_lim;
  logic             store_en, job_en, job_name;
  logic [1:0]       job_code;

  function automatic act_t name_act(input logic [7:0] b, input logic [7:0] term,
                                    input logic full);
    act_t a;
    if (b == CH_NUL) begin
      a = ACT_NONE;
    end else if (b == term) begin
      a = full ? ACT_OVERFLOW : ACT_FINISH;
    end else begin
      a = full ? ACT_OVERFLOW : ACT_STORE;
    end
    return a;
  endfunction

  // both banks busy means the next name would overwrite one being sent
  assign in_ready = !q_full && (in_flight != 2'd2);
  assign accept   = in_valid && in_ready;

  assign blank    = (data_byte <= CH_BLANK_MAX);
  assign lim_ext  = CMP_W'(name_limit);
  assign depth_c  = CMP_W'(NAME_DEPTH);
  assign eff_lim  = (lim_ext < depth_c) ? lim_ext : depth_c;
  assign at_limit = (CMP_W'(name_length) >= eff_lim);

  // byte and end marker classification
  always_comb begin
    act     = ACT_NONE;
    ph_byte = phase;
    if (has_byte) begin
      unique case (phase)
        PH_LEAD: begin
          if (!blank) begin
            if (format_json) begin
              if (data_byte == CH_LBRACE) ph_byte = PH_JQUOTE;
              else act = ACT_INVALID;
            end else begin
              if (data_byte == CH_LT) ph_byte = PH_LT0;
              else act = ACT_INVALID;
            end
          end
        end
        PH_LT0: begin
          if (blank) begin
            ph_byte = PH_LTSP;
          end else if (data_byte == CH_QMARK) begin
            ph_byte = PH_HDR;
          end else begin
            ph_byte = PH_XNAME;
            act     = name_act(data_byte, CH_GT, at_limit);
          end
        end
        PH_LTSP: begin
          if (!blank) begin
            if (data_byte == CH_QMARK) ph_byte = PH_HDR;
            else if (data_byte == CH_LT) ph_byte = PH_XNAME;
            else act = ACT_INVALID;
          end
        end
        PH_HDR: begin
          if (data_byte == CH_GT) ph_byte = PH_MAINLEAD;
        end
        PH_MAINLEAD: begin
          if (!blank) begin
            if (data_byte == CH_LT) ph_byte = PH_XNAME;
            else act = ACT_INVALID;
          end
        end
        PH_XNAME: act = name_act(data_byte, CH_GT, at_limit);
        PH_JQUOTE: begin
          if (!blank) begin
            if (data_byte == CH_QUOTE) ph_byte = PH_JNAME;
            else act = ACT_INVALID;
          end
        end
        PH_JNAME: act = name_act(data_byte, CH_QUOTE, at_limit);
        PH_DONE: ;
        default: ;
      endcase
    end

    store_en = (act == ACT_STORE);
    job_name = (act == ACT_FINISH);
    job_en   = (act == ACT_FINISH) || (act == ACT_INVALID) || (act == ACT_OVERFLOW);
    job_code = (act == ACT_INVALID) ? ST_INVALID : ((act == ACT_OVERFLOW) ? ST_OVERFLOW : ST_OK);

    // end of document with no result yet
    if (end_of_source && !job_en) begin
      unique case (ph_byte)
        PH_DONE: ;
        PH_LT0, PH_XNAME, PH_JNAME: begin
          job_en   = 1'b1;
          job_code = ST_OVERFLOW;
        end
        default: begin
          job_en   = 1'b1;
          job_code = ST_INVALID;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    name_length_next = name_length;
    if (accept) begin
      if (end_of_source) begin
        phase_next       = PH_LEAD;
        name_length_next = '0;
      end else begin
        phase_next       = job_en ? PH_DONE : ph_byte;
        name_length_next = store_en ? name_length + LEN_W'(1) : name_length;
      end
    end
  end

  // outputs
  always_comb begin
    push             = accept && job_en;
    push_job.is_name = job_name;
    push_job.code    = job_code;
    push_job.len     = JOB_LEN_W'(name_length);
    push_job.bank    = wr_bank;
    mem_we           = accept && store_en;
    mem_waddr        = {wr_bank, name_length[IDX_W-1:0]};
    mem_wdata        = data_byte;
  end

  assign in_flight_next = in_flight + {1'b0, push && job_name} - {1'b0, release_bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      name_length <= '0;
      wr_bank     <= 1'b0;
      in_flight   <= 2'd0;
    end else begin
      phase       <= phase_next;
      name_length <= name_length_next;
      in_flight   <= in_flight_next;
      if (push && job_name) wr_bank <= !wr_bank;
    end
  end

  `RENS_ASSERT_IMPLY(a_push_room, clk, rst, push, !q_full)
  `RENS_ASSERT_IMPLY(a_store_in_range, clk, rst, mem_we, name_length < LEN_W'(NAME_DEPTH))
  `RENS_ASSERT_IMPLY(a_release_owned, clk, rst, release_bank, in_flight != 2'd0)
  `RENS_ASSERT_NEXT(a_both_banks_stall, clk, rst, in_flight == 2'd2 && !release_bank, !in_ready)

endmodule

`default_nettype wire

>>> rtl/core/rens_job_queue.sv
// ----------------------------------------------------------------------------
// root name scanner job queue
// two entry queue of result jobs between front end and emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rens_job_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rens_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output rens_pkg::job_t      q_job
);
  import rens_pkg::*;

  job_t       slot [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = slot[rp];

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rens_back.sv
// ----------------------------------------------------------------------------
// root name scanner emitter
// holds the two-bank name memory and plays jobs out as result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rens_back #(
  parameter int NAME_DEPTH = rens_pkg::NAME_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire rens_pkg::job_t         q_job,
  output logic                        pop,
  input  wire logic                   mem_we,
  input  wire logic [$clog2(NAME_DEPTH):0] mem_waddr,
  input  wire logic [7:0]             mem_wdata,
  output logic                        release_bank,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [7:0]                  name_char,
  output logic                        run_last
);
  import rens_pkg::*;

  localparam int IDX_W     = $clog2(NAME_DEPTH);
  localparam int LEN_W     = $clog2(NAME_DEPTH + 1);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [7:0] name_mem [MEM_DEPTH];

  logic             cur_valid;
  job_t             cur_job;
  logic [LEN_W-1:0] idx, cur_len;
  logic             gen, gen_char, cur_finish;

  logic             s1_valid, s1_en, s1_is_char, s1_last;
  logic [1:0]       s1_status;
  logic [7:0]       mem_q;
  logic             s2_load;

  assign cur_len    = cur_job.len[LEN_W-1:0];
  assign s2_load    = s1_valid && (!out_valid || out_ready);
  assign s1_en      = !s1_valid || s2_load;
  assign gen        = cur_valid && s1_en;
  assign gen_char   = cur_job.is_name && (idx != cur_len);
  assign cur_finish = gen && !gen_char;
  assign pop        = q_valid && (!cur_valid || cur_finish);
  // all reads of the bank are issued once the terminator is generated
  assign release_bank = cur_finish && cur_job.is_name;

  always_ff @(posedge clk) begin
    if (mem_we) name_mem[mem_waddr] <= mem_wdata;
    if (gen && gen_char) mem_q <= name_mem[{cur_job.bank, idx[IDX_W-1:0]}];
  end

  // job sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (cur_finish) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_job <= q_job;
      idx     <= '0;
    end else if (gen && gen_char) begin
      idx <= idx + LEN_W'(1);
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_status  <= cur_job.is_name ? ST_OK : cur_job.code;
      s1_is_char <= gen_char;
      s1_last    <= !gen_char;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      status    <= s1_status;
      name_char <= s1_is_char ? mem_q : CH_NUL;
      run_last  <= s1_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/root_element_name_scanner_core.sv
// ----------------------------------------------------------------------------
// root name scanner core
// finds the root element name (xml) or first key (json) of a byte stream
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_ready   data_byte, has_byte, end_of_source
//  out       source     out_valid / out_ready status, name_char, run_last
//  cfg       sink       cfg_we                cfg_index, cfg_data
//
// one input byte per cycle while in_ready is high; the phase update and name
// store write happen in the cycle the request is taken
// a name of n bytes plays out as n + 1 items, one per cycle while out_ready is
// high, through a read stage and the output register; the closing request's
// job first passes the two entry job queue and the job sequencer
// the name memory has two banks, so input stalls only while two names are
// still queued or playing out, or the two entry job queue is full
// synchronous reset; the name memory is not cleared, only written entries
// are ever read
`timescale 1ns / 1ps
`default_nettype none

module root_element_name_scanner_core #(
  parameter int NAME_DEPTH = rens_pkg::NAME_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            has_byte,
  input  wire logic                            end_of_source,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           status,
  output logic [7:0]                           name_char,
  output logic                                 run_last,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [rens_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rens_pkg::*;

  localparam int ADDR_W = $clog2(NAME_DEPTH) + 1;

  logic                  format_json;
  logic [CFG_DATA_W-1:0] name_limit;

  logic              q_full, q_valid, push, pop, release_bank;
  job_t              push_job, q_job;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_json <= 1'b0;
      name_limit  <= NAME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT_JSON: format_json <= cfg_data[0];
        CFG_NAME_LIMIT:  name_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  rens_front #(
    .NAME_DEPTH(NAME_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .format_json  (format_json),
    .name_limit   (name_limit),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .end_of_source(end_of_source),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .release_bank (release_bank)
  );

  rens_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  rens_back #(
    .NAME_DEPTH(NAME_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .release_bank(release_bank),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .name_char   (name_char),
    .run_last    (run_last)
  );

endmodule

`default_nettype wire

>>> verif/root_element_name_scanner_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// root name scanner core testbench
// streams xml and json documents through the scanner with bursty requests and
// a stalling sink, predicts every name run and status item in step with the
// accepted bytes, and compares each output item field by field
// ----------------------------------------------------------------------------

module root_element_name_scanner_core_test;
  import rens_pkg::*;

  localparam int DEPTH         = NAME_DEPTH_DEF;
  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } byte_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ch;
    logic       last;
  } name_item_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;
  typedef enum {DOC_PLAIN, DOC_QUIRK, DOC_CUT, DOC_NOISE, DOC_STUB} doc_kind_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte     = '0;
  logic                  has_byte      = 1'b0;
  logic                  end_of_source = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [1:0]            status;
  logic [7:0]            name_char;
  logic                  run_last;
  logic                  cfg_we        = 1'b0;
  logic                  cfg_index     = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  root_element_name_scanner_core #(
    .NAME_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .end_of_source(end_of_source),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .name_char    (name_char),
    .run_last     (run_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // scanner mirror
  phase_t     doc_phase = PH_LEAD;
  logic [7:0] name_buf [DEPTH];
  int         name_len  = 0;
  logic       cfg_json  = 1'b0;
  logic [5:0] cfg_limit = NAME_LIMIT_RST;
  bit         run_emitted;

  name_item_t expected_chars[$];
  byte_req_t  doc_bytes[$];
  logic [7:0] doc_body[$];
  byte_req_t  in_req;
  name_item_t mon_got, mon_want;

  int queued_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  bit hold_wanted    = 1'b0;
  bit hold_done      = 1'b0;
  rx_mode_t stall_mode = RX_OPEN;
  int       stall_left = 0;
  logic [7:0] stall_pat = 8'hFF;
  logic       ready_next;

  function automatic int name_cap();
    return (int'(cfg_limit) < DEPTH) ? int'(cfg_limit) : DEPTH;
  endfunction

  task automatic emit_status(input logic [1:0] code);
    expected_chars.push_back(name_item_t'{code, CH_NUL, 1'b1});
    doc_phase   = PH_DONE;
    run_emitted = 1'b1;
  endtask

  task automatic emit_name();
    if (name_len >= name_cap()) begin
      emit_status(ST_OVERFLOW);
    end else begin
      for (int k = 0; k < name_len; k++)
        expected_chars.push_back(name_item_t'{ST_OK, name_buf[k], 1'b0});
      expected_chars.push_back(name_item_t'{ST_OK, CH_NUL, 1'b1});
      doc_phase   = PH_DONE;
      run_emitted = 1'b1;
    end
  endtask

  task automatic accept_name_byte(input logic [7:0] b, input logic [7:0] term);
    if (b == CH_NUL) begin
      // nulls inside a name are dropped
    end else if (b == term) begin
      emit_name();
    end else if (name_len >= name_cap()) begin
      emit_status(ST_OVERFLOW);
    end else begin
      name_buf[name_len] = b;
      name_len++;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    case (doc_phase)
      PH_LEAD: begin
        if (b > CH_BLANK_MAX) begin
          if (cfg_json) begin
            if (b == CH_LBRACE) doc_phase = PH_JQUOTE;
            else emit_status(ST_INVALID);
          end else if (b == CH_LT) begin
            doc_phase = PH_LT0;
          end else begin
            emit_status(ST_INVALID);
          end
        end
      end
      PH_LT0: begin
        if (b <= CH_BLANK_MAX) doc_phase = PH_LTSP;
        else if (b == CH_QMARK) doc_phase = PH_HDR;
        else begin
          doc_phase = PH_XNAME;
          accept_name_byte(b, CH_GT);
        end
      end
      PH_LTSP: begin
        // blanks after '<': only a header or a second '<' may follow
        if (b == CH_QMARK) doc_phase = PH_HDR;
        else if (b == CH_LT) doc_phase = PH_XNAME;
        else if (b > CH_BLANK_MAX) emit_status(ST_INVALID);
      end
      PH_HDR: begin
        if (b == CH_GT) doc_phase = PH_MAINLEAD;
      end
      PH_MAINLEAD: begin
        if (b == CH_LT) doc_phase = PH_XNAME;
        else if (b > CH_BLANK_MAX) emit_status(ST_INVALID);
      end
      PH_XNAME: accept_name_byte(b, CH_GT);
      PH_JQUOTE: begin
        if (b == CH_QUOTE) doc_phase = PH_JNAME;
        else if (b > CH_BLANK_MAX) emit_status(ST_INVALID);
      end
      PH_JNAME: accept_name_byte(b, CH_QUOTE);
      default: begin
      end
    endcase
  endtask

  task automatic scan_request(input byte_req_t r);
    run_emitted = 1'b0;
    if (r.has) scan_byte(r.data);
    if (r.eos) begin
      if (!run_emitted) begin
        case (doc_phase)
          PH_DONE: begin
          end
          PH_LT0, PH_XNAME, PH_JNAME: emit_status(ST_OVERFLOW);
          default: emit_status(ST_INVALID);
        endcase
      end
      doc_phase = PH_LEAD;
      name_len  = 0;
    end
  endtask

  // request source
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_request(in_req);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (doc_bytes.size() != 0) begin
          in_req = doc_bytes.pop_front();
          data_byte     <= in_req.data;
          has_byte      <= in_req.has;
          end_of_source <= in_req.eos;
          in_valid      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long sink hold-off so the name banks and job queue fill up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
        stall_pat  = 8'($urandom) | 8'h01;
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RX_OPEN:   ready_next = 1'b1;
        RX_COIN:   ready_next = 1'($urandom_range(0, 1));
        RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
        default: begin
          ready_next = stall_pat[0];
          stall_pat  = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
      out_ready <= ready_next && (hold_left == 0);
    end
  end

  task automatic log_mismatch(input string what, input name_item_t want, input name_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s) at %0t: expected status %0d char %02h last %0b",
               what, $realtime, want.status, want.ch, want.last);
      $display("  got status %0d char %02h last %0b", got.status, got.ch, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      mon_got = name_item_t'{status, name_char, run_last};
      if (expected_chars.size() == 0) begin
        log_mismatch("no request pending", '0, mon_got);
      end else begin
        mon_want = expected_chars.pop_front();
        if (mon_got.status !== mon_want.status || mon_got.ch !== mon_want.ch ||
            mon_got.last !== mon_want.last)
          log_mismatch("field", mon_want, mon_got);
      end
    end
  end

  task automatic push_req(input logic [7:0] b, input logic hb, input logic eos);
    doc_bytes.push_back(byte_req_t'{b, hb, eos});
    queued_count++;
  endtask

  function automatic logic [7:0] name_fill(input logic [7:0] term);
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) return CH_NUL;
    do b = 8'($urandom_range(0, 255)); while (b == term);
    return b;
  endfunction

  task automatic add_blanks(input int most);
    repeat ($urandom_range(0, most)) doc_body.push_back(8'($urandom_range(0, 32)));
  endtask

  task automatic add_name(input logic [7:0] term);
    int cap, n;
    logic [7:0] b;
    cap = name_cap();
    case ($urandom_range(0, 9))
      0: n = cap;
      1: n = cap + 1;
      2: n = 0;
      3: n = (cap > 0) ? cap - 1 : 0;
      4: n = (cap > 1) ? $urandom_range(1, cap - 1) : 1;
      default: n = $urandom_range(1, (cap > 1 && cap < 9) ? cap - 1 : 8);
    endcase
    for (int k = 0; k < n; k++) begin
      b = name_fill(term);
      // a blank or '?' right after '<' would not start an xml name
      while (k == 0 && term == CH_GT && (b <= CH_BLANK_MAX || b == CH_QMARK))
        b = name_fill(term);
      doc_body.push_back(b);
    end
    doc_body.push_back(term);
  endtask

  task automatic add_doc();
    doc_kind_t kind;
    int r, sel, cut;
    logic [7:0] b;
    logic with_hdr, last_eos;
    doc_body.delete();
    r    = $urandom_range(0, 9);
    kind = (r <= 5) ? DOC_PLAIN : (r == 6) ? DOC_QUIRK : (r == 7) ? DOC_CUT :
           (r == 8) ? DOC_NOISE : DOC_STUB;
    sel  = $urandom_range(0, 2);
    case (kind)
      DOC_NOISE: repeat ($urandom_range(1, 6)) doc_body.push_back(8'($urandom_range(0, 255)));
      DOC_STUB: begin
        if (sel != 0) begin
          add_blanks(2);
          doc_body.push_back(cfg_json ? CH_LBRACE : CH_LT);
        end
      end
      default: begin
        add_blanks(3);
        if (cfg_json) begin
          doc_body.push_back(CH_LBRACE);
          add_blanks(2);
          if (kind == DOC_QUIRK) begin
            do b = 8'($urandom_range(33, 255)); while (b == CH_QUOTE);
            doc_body.push_back(b);
          end else begin
            doc_body.push_back(CH_QUOTE);
            add_name(CH_QUOTE);
          end
        end else begin
          with_hdr = (kind == DOC_QUIRK) ? (sel == 0) : ($urandom_range(0, 2) == 0);
          if (kind == DOC_QUIRK) begin
            doc_body.push_back(CH_LT);
            doc_body.push_back(8'($urandom_range(0, 32)));
            add_blanks(1);
          end
          if (kind == DOC_QUIRK && sel == 2) begin
            do b = 8'($urandom_range(33, 255)); while (b == CH_QMARK || b == CH_LT);
            doc_body.push_back(b);
          end else begin
            if (with_hdr) begin
              if (kind != DOC_QUIRK) doc_body.push_back(CH_LT);
              doc_body.push_back(CH_QMARK);
              repeat ($urandom_range(0, 4)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_GT);
                doc_body.push_back(b);
              end
              doc_body.push_back(CH_GT);
              add_blanks(2);
            end
            doc_body.push_back(CH_LT);
            add_name(CH_GT);
          end
        end
        if (kind == DOC_CUT) begin
          cut = $urandom_range(0, doc_body.size() - 1);
          while (doc_body.size() > cut) void'(doc_body.pop_back());
        end else if ($urandom_range(0, 2) == 0) begin
          // trailing bytes after the run are ignored
          repeat ($urandom_range(1, 2)) doc_body.push_back(8'($urandom_range(0, 255)));
        end
      end
    endcase
    last_eos = (doc_body.size() != 0) && ($urandom_range(0, 1) == 1);
    foreach (doc_body[k]) begin
      if ($urandom_range(0, 11) == 0) push_req(8'($urandom), 1'b0, 1'b0);
      push_req(doc_body[k], 1'b1, last_eos && (k == doc_body.size() - 1));
    end
    if (!last_eos) push_req(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic set_config(input logic json, input logic [5:0] lim);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FORMAT_JSON;
    cfg_data  <= CFG_DATA_W'(json);
    @(posedge clk);
    cfg_index <= CFG_NAME_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_json  = json;
    cfg_limit = lim;
  endtask

  task automatic drain();
    while (accepted_count != queued_count) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    logic [5:0] lim;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // xml, limit 32 after reset
    push_req(CH_NUL, 1'b1, 1'b0);
    push_req(CH_BLANK_MAX, 1'b1, 1'b0);
    push_req(CH_LT, 1'b1, 1'b1);          // lone '<' then end: overflow
    push_req(CH_LT, 1'b1, 1'b0);          // header, then name with a null in it
    push_req(CH_QMARK, 1'b1, 1'b0);
    push_req(8'hFF, 1'b1, 1'b0);
    push_req(CH_GT, 1'b1, 1'b0);
    push_req(CH_LT, 1'b1, 1'b0);
    push_req(8'h61, 1'b1, 1'b0);
    push_req(CH_NUL, 1'b1, 1'b0);
    push_req(CH_GT, 1'b1, 1'b0);
    push_req(8'h7A, 1'b1, 1'b0);          // ignored after the run
    push_req(8'hA5, 1'b0, 1'b1);          // end marker, nothing more
    push_req(CH_LT, 1'b1, 1'b0);          // blank after '<' then '<' opens the name
    push_req(8'h20, 1'b1, 1'b0);
    push_req(CH_LT, 1'b1, 1'b0);
    push_req(8'h62, 1'b1, 1'b0);
    push_req(CH_GT, 1'b1, 1'b1);
    push_req(CH_LT, 1'b1, 1'b0);          // blank after '<' then other byte: invalid
    push_req(8'h09, 1'b1, 1'b0);
    push_req(8'h78, 1'b1, 1'b0);
    push_req(CH_NUL, 1'b0, 1'b1);
    push_req(8'h5A, 1'b0, 1'b0);          // empty step
    push_req(CH_LT, 1'b1, 1'b0);          // header never closed
    push_req(CH_QMARK, 1'b1, 1'b1);
    push_req(8'hFF, 1'b0, 1'b1);          // end before anything
    drain();

    // json with a zero limit
    set_config(1'b1, 6'd0);
    push_req(CH_LBRACE, 1'b1, 1'b0);
    push_req(CH_QUOTE, 1'b1, 1'b0);
    push_req(CH_QUOTE, 1'b1, 1'b1);
    push_req(8'h20, 1'b1, 1'b0);
    push_req(CH_LBRACE, 1'b1, 1'b0);
    push_req(CH_QUOTE, 1'b1, 1'b0);
    push_req(8'h71, 1'b1, 1'b0);
    push_req(CH_NUL, 1'b0, 1'b1);
    push_req(CH_LT, 1'b1, 1'b1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0, 1:    lim = 6'd32;
        2:       lim = 6'd1;
        3:       lim = 6'd5;
        4:       lim = 6'd0;
        5:       lim = 6'd2;
        default: lim = 6'($urandom_range(2, 31));
      endcase
      set_config(p[0], lim);
      if (p == 1) hold_wanted = 1'b1;
      target = queued_count + ((p == 1) ? 52 : 24);
      while (queued_count < target) add_doc();
      drain();
    end

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> root_element_name_scanner_core.f
+incdir+rtl/core
rtl/core/rens_pkg.sv
rtl/core/rens_front.sv
rtl/core/rens_job_queue.sv
rtl/core/rens_back.sv
rtl/core/root_element_name_scanner_core.sv
verif/root_element_name_scanner_core_test.sv
